// ===== src/smxj_pkg.sv =====
// Shared types, constants and tables for the softmax / Jacobian block.
// No dependencies; every other file but smxj_fifo imports it.
`timescale 1ns / 1ps
`default_nettype none

package smxj_pkg;

  localparam int unsigned CAUSE_W = 3;
  localparam int unsigned X_W     = 16;
  localparam int unsigned EXP_W   = 32;
  localparam int unsigned DEN_W   = 36;
  localparam int unsigned Q_W     = 31;
  localparam int unsigned TAYLOR_TERMS = 14;

  localparam logic [DEN_W-1:0] ONE_Q20 = DEN_W'(1) << 20;
  localparam logic [Q_W-1:0]   ONE_Q30 = Q_W'(1) << 30;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_MUL,
    EX_RCP,
    EX_COR,
    EX_SQ,
    EX_FIN
  } exp_state_e;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_X0,
    FR_W0,
    FR_X1,
    FR_W1,
    FR_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_LD0,
    BK_LD1,
    BK_RD,
    BK_DINIT,
    BK_DIV,
    BK_QWR,
    BK_QK,
    BK_QKL,
    BK_QD,
    BK_MUL,
    BK_EMIT
  } back_state_e;

  // One loaded cause: both exponentials plus how it fits in the evaluation.
  typedef struct packed {
    logic [EXP_W-1:0]   e0;
    logic [EXP_W-1:0]   e1;
    logic [CAUSE_W-1:0] slot;
    logic [CAUSE_W-1:0] n;
    logic               last;
  } mid_t;

  typedef struct packed {
    logic               individual;
    logic [CAUSE_W-1:0] cause_index;
    logic [CAUSE_W-1:0] wrt_cause;
    logic [15:0]        probability;
    logic [14:0]        prob_slope;
    logic [16:0]        log_prob_slope;
    logic               last_result;
  } res_t;

  // Exponential unit handshake.
  typedef struct packed {
    logic             done;
    logic [EXP_W-1:0] e;
  } exp_rsp_t;

  // floor(2^32 / k), k = 1 saturates; one correction step follows.
  function automatic logic [31:0] recip_tab(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd1:    r = 32'hFFFF_FFFF;
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      4'd13:   r = 32'h13B1_3B13;
      4'd14:   r = 32'h1249_2492;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Saturating Q4.12 add.
  function automatic logic signed [X_W-1:0] sat_add(input logic signed [X_W-1:0] a,
                                                    input logic signed [X_W-1:0] b);
    logic signed [X_W:0] s;
    logic signed [X_W-1:0] r;
    s = (X_W+1)'(a) + (X_W+1)'(b);
    if (s > 17'sd32767) begin
      r = 16'sh7FFF;
    end else if (s < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = s[X_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/smxj_fifo.sv =====
// Small register FIFO used between front and back and on the result side.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module smxj_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/smxj_exp.sv =====
// Iterative fixed-point exponential: 14-term Taylor on x/16, then four squarings.
// Depends on smxj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smxj_exp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [15:0]     x_i,
  output smxj_pkg::exp_rsp_t     rsp_o
);
  import smxj_pkg::*;

  exp_state_e state_q, state_d;

  logic signed [29:0] t_q;
  logic signed [31:0] term_q;
  logic signed [32:0] sum_q;
  logic [3:0]         k_q;
  logic signed [61:0] prod_q;
  logic [29:0]        m_q;
  logic               neg_q;
  logic [29:0]        est_q;
  logic [37:0]        r_q;
  logic [1:0]         sq_q;

  logic [61:0]        prod_abs;
  logic [61:0]        rcp_prod;
  logic [33:0]        rem;
  logic [29:0]        qv;
  logic signed [31:0] term_nx;
  logic signed [32:0] sum_nx;
  logic [64:0]        sq_full;

  assign prod_abs = prod_q[61] ? 62'(-prod_q) : 62'(prod_q);
  assign rcp_prod = 62'(prod_abs[59:30]) * 62'(recip_tab(k_q));
  assign rem      = 34'(m_q) - 34'(est_q) * 34'(k_q);
  assign qv       = est_q + 30'(rem >= 34'(k_q));
  assign term_nx  = neg_q ? -$signed({2'b00, qv}) : $signed({2'b00, qv});
  assign sum_nx   = sum_q + 33'(term_nx);
  assign sq_full  = 65'(r_q[31:0]) * 65'(r_q[31:0]) + (65'(1) << 25);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      EX_IDLE: if (start_i) state_d = EX_MUL;
      EX_MUL:  state_d = EX_RCP;
      EX_RCP:  state_d = EX_COR;
      EX_COR:  state_d = (k_q == 4'(TAYLOR_TERMS)) ? EX_SQ : EX_MUL;
      EX_SQ:   if (sq_q == 2'd3) state_d = EX_FIN;
      EX_FIN:  state_d = EX_IDLE;
      default: state_d = EX_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp_o.done = (state_q == EX_FIN);
    rsp_o.e    = 32'((r_q + 38'd32) >> 6);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EX_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      EX_IDLE: begin
        t_q    <= $signed({x_i, 14'b0});
        term_q <= 32'sd1 <<< 30;
        sum_q  <= 33'sd1 <<< 30;
        k_q    <= 4'd1;
        sq_q   <= 2'd0;
      end
      EX_MUL: prod_q <= 62'(term_q) * 62'(t_q);
      EX_RCP: begin
        m_q   <= prod_abs[59:30];
        neg_q <= prod_q[61];
        est_q <= rcp_prod[61:32];
      end
      EX_COR: begin
        term_q <= term_nx;
        sum_q  <= sum_nx;
        k_q    <= k_q + 4'd1;
        r_q    <= 38'(sum_nx + 33'sd8) >> 4;
      end
      EX_SQ: begin
        r_q  <= sq_full[63:26];
        sq_q <= sq_q + 2'd1;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/smxj_front.sv =====
// Front: takes input beats, classifies them in the load sequence, runs exponentials.
// Depends on smxj_pkg and smxj_exp.
`timescale 1ns / 1ps
`default_nettype none

module smxj_front #(
  parameter int unsigned MAX_CAUSES = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [15:0]            beta_first_i,
  input  logic signed [15:0]            beta_second_i,
  input  logic signed [15:0]            random_effect_i,
  input  logic [smxj_pkg::CAUSE_W-1:0]  cause_count_i,
  output logic                          mid_push_o,
  output smxj_pkg::mid_t                mid_o,
  input  logic                          mid_full_i
);
  import smxj_pkg::*;

  front_state_e state_q, state_d;

  logic signed [15:0] b0_q, b1_q, u_q;
  logic [CAUSE_W-1:0] loaded_q, slot_q, n_q;
  logic               last_q;
  logic [EXP_W-1:0]   e0_q, e1_q;

  logic [CAUSE_W-1:0] n_eff, slot_nx;
  logic               last_nx;
  logic               exp_start;
  logic signed [15:0] exp_x;
  exp_rsp_t           exp_rsp;

  always_comb begin
    if (cause_count_i == '0) begin
      n_eff = CAUSE_W'(1);
    end else if (cause_count_i > CAUSE_W'(MAX_CAUSES)) begin
      n_eff = CAUSE_W'(MAX_CAUSES);
    end else begin
      n_eff = cause_count_i;
    end
  end

  assign slot_nx = (loaded_q >= n_eff) ? '0 : loaded_q;
  assign last_nx = ((slot_nx + CAUSE_W'(1)) >= n_eff);

  smxj_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (exp_start),
    .x_i     (exp_x),
    .rsp_o   (exp_rsp)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: if (push_i) state_d = FR_X0;
      FR_X0:   state_d = FR_W0;
      FR_W0:   if (exp_rsp.done) state_d = FR_X1;
      FR_X1:   state_d = FR_W1;
      FR_W1:   if (exp_rsp.done) state_d = FR_PUSH;
      FR_PUSH: if (!mid_full_i) state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    full_o     = (state_q != FR_IDLE);
    exp_start  = (state_q == FR_X0) || (state_q == FR_X1);
    exp_x      = (state_q == FR_X1) ? sat_add(b1_q, u_q) : sat_add(b0_q, u_q);
    mid_push_o = (state_q == FR_PUSH);
    mid_o.e0   = e0_q;
    mid_o.e1   = e1_q;
    mid_o.slot = slot_q;
    mid_o.n    = n_q;
    mid_o.last = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FR_IDLE;
      loaded_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == FR_IDLE && push_i) begin
        loaded_q <= last_nx ? '0 : slot_nx + CAUSE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FR_IDLE && push_i) begin
      b0_q   <= beta_first_i;
      b1_q   <= beta_second_i;
      u_q    <= random_effect_i;
      slot_q <= slot_nx;
      n_q    <= n_eff;
      last_q <= last_nx;
    end
    if (state_q == FR_W0 && exp_rsp.done) begin
      e0_q <= exp_rsp.e;
    end
    if (state_q == FR_W1 && exp_rsp.done) begin
      e1_q <= exp_rsp.e;
    end
  end

endmodule

`default_nettype wire

// ===== src/smxj_back.sv =====
// Back: stores exponentials and denominators, divides, emits probability/Jacobian beats.
// Depends on smxj_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smxj_back #(
  parameter int unsigned MAX_CAUSES = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  smxj_pkg::mid_t  mid_i,
  input  logic            mid_empty_i,
  output logic            mid_pop_o,
  output logic            res_push_o,
  output smxj_pkg::res_t  res_o,
  input  logic            res_full_i
);
  import smxj_pkg::*;

  localparam int unsigned ST_DEPTH = 2 * MAX_CAUSES;
  localparam int unsigned ST_AW    = $clog2(ST_DEPTH);
  localparam int unsigned QM_AW    = (MAX_CAUSES > 1) ? $clog2(MAX_CAUSES) : 1;

  back_state_e state_q, state_d;

  mid_t               ent_q;
  logic [DEN_W-1:0]   den0_q, den1_q;
  logic               j_q;
  logic [CAUSE_W-1:0] k_q, d_q;
  logic [DEN_W-1:0]   rem_q;
  logic [Q_W-1:0]     nlo_q, quo_q, qk_q, qd_q;
  logic [4:0]         cnt_q;
  logic [61:0]        prod_q;
  logic               diag_q;

  logic [EXP_W-1:0]   st_mem [ST_DEPTH];
  logic [EXP_W-1:0]   st_rd_q;
  logic [Q_W-1:0]     q_mem [MAX_CAUSES];
  logic [Q_W-1:0]     q_rd_q;

  logic               st_we;
  logic [ST_AW-1:0]   st_waddr, st_raddr;
  logic [EXP_W-1:0]   st_wdata;
  logic [QM_AW-1:0]   q_raddr;

  logic [DEN_W-1:0]   den_sel;
  logic [62:0]        num;
  logic [DEN_W:0]     rem2;
  logic               ge;
  logic [CAUSE_W-1:0] n_m1;
  logic [Q_W-1:0]     rest, mul_b;
  logic [15:0]        sl, pk, pd;
  logic [17:0]        lg;
  logic [15:0]        slope;

  assign n_m1     = ent_q.n - CAUSE_W'(1);
  assign den_sel  = j_q ? den1_q : den0_q;
  assign num      = (63'(st_rd_q) << 30) + 63'(den_sel >> 1);
  assign rem2     = {rem_q, nlo_q[Q_W-1]};
  assign ge       = (rem2 >= (DEN_W+1)'(den_sel));
  assign rest     = (qk_q <= ONE_Q30) ? ONE_Q30 - qk_q : '0;
  assign mul_b    = (d_q == k_q) ? rest : q_rd_q;
  assign sl       = 16'((prod_q + (62'(1) << 44)) >> 45);
  assign pk       = 16'((32'(qk_q) + 32'd16384) >> 15);
  assign pd       = 16'((32'(qd_q) + 32'd16384) >> 15);
  assign lg       = diag_q ? 18'(17'd32768) - 18'(pk) : 18'd0 - 18'(pd);
  assign slope    = diag_q ? sl : 16'd0 - sl;

  assign st_we    = (state_q == BK_LD0) || (state_q == BK_LD1);
  assign st_waddr = ST_AW'(ent_q.slot) + ((state_q == BK_LD1) ? ST_AW'(MAX_CAUSES) : '0);
  assign st_wdata = (state_q == BK_LD1) ? ent_q.e1 : ent_q.e0;
  assign st_raddr = ST_AW'(k_q) + (j_q ? ST_AW'(MAX_CAUSES) : '0);
  assign q_raddr  = (state_q == BK_QD) ? QM_AW'(d_q) : QM_AW'(k_q);

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rd_q <= st_mem[st_raddr];
    if (state_q == BK_QWR) begin
      q_mem[QM_AW'(k_q)] <= quo_q;
    end
    q_rd_q <= q_mem[q_raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:  if (!mid_empty_i) state_d = BK_LD0;
      BK_LD0:   state_d = BK_LD1;
      BK_LD1:   state_d = ent_q.last ? BK_RD : BK_IDLE;
      BK_RD:    state_d = BK_DINIT;
      BK_DINIT: state_d = BK_DIV;
      BK_DIV:   if (cnt_q == 5'd0) state_d = BK_QWR;
      BK_QWR:   state_d = (k_q == n_m1) ? BK_QK : BK_RD;
      BK_QK:    state_d = BK_QKL;
      BK_QKL:   state_d = BK_QD;
      BK_QD:    state_d = BK_MUL;
      BK_MUL:   state_d = BK_EMIT;
      BK_EMIT: begin
        if (!res_full_i) begin
          if (d_q != n_m1) begin
            state_d = BK_QD;
          end else if (k_q != n_m1) begin
            state_d = BK_QK;
          end else if (!j_q) begin
            state_d = BK_RD;
          end else begin
            state_d = BK_IDLE;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    mid_pop_o            = (state_q == BK_IDLE) && !mid_empty_i;
    res_push_o           = (state_q == BK_EMIT) && !res_full_i;
    res_o.individual     = j_q;
    res_o.cause_index    = k_q;
    res_o.wrt_cause      = d_q;
    res_o.probability    = pk;
    res_o.prob_slope     = slope[14:0];
    res_o.log_prob_slope = lg[16:0];
    res_o.last_result    = j_q && (k_q == n_m1) && (d_q == n_m1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      den0_q  <= ONE_Q20;
      den1_q  <= ONE_Q20;
      j_q     <= 1'b0;
      k_q     <= '0;
      d_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        BK_LD0: den0_q <= ((ent_q.slot == '0) ? ONE_Q20 : den0_q) + DEN_W'(ent_q.e0);
        BK_LD1: begin
          den1_q <= ((ent_q.slot == '0) ? ONE_Q20 : den1_q) + DEN_W'(ent_q.e1);
          j_q    <= 1'b0;
          k_q    <= '0;
        end
        BK_QWR: k_q <= (k_q == n_m1) ? '0 : k_q + CAUSE_W'(1);
        BK_QKL: d_q <= '0;
        BK_EMIT: begin
          if (!res_full_i) begin
            if (d_q != n_m1) begin
              d_q <= d_q + CAUSE_W'(1);
            end else if (k_q != n_m1) begin
              k_q <= k_q + CAUSE_W'(1);
            end else begin
              j_q <= 1'b1;
              k_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: if (!mid_empty_i) ent_q <= mid_i;
      BK_DINIT: begin
        rem_q <= DEN_W'(num[62:31]);
        nlo_q <= num[30:0];
        cnt_q <= 5'd30;
      end
      BK_DIV: begin
        rem_q <= ge ? DEN_W'(rem2 - (DEN_W+1)'(den_sel)) : rem2[DEN_W-1:0];
        quo_q <= {quo_q[Q_W-2:0], ge};
        nlo_q <= {nlo_q[Q_W-2:0], 1'b0};
        cnt_q <= cnt_q - 5'd1;
      end
      BK_QKL: qk_q <= q_rd_q;
      BK_MUL: begin
        qd_q   <= q_rd_q;
        diag_q <= (d_q == k_q);
        prod_q <= 62'(qk_q) * 62'(mul_b);
      end
      default: ;
    endcase
  end

  // a probability never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_QWR) |-> (quo_q <= ONE_Q30))
    else $error("quotient above one");

  // the last division step always hands over to the quotient write
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV && cnt_q == 5'd0) |=> (state_q == BK_QWR))
    else $error("divider did not finish");

  // loads never overlap an evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop_o |-> (state_q == BK_IDLE))
    else $error("queue popped while busy");

  // the final beat of an evaluation returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && res_o.last_result) |=> (state_q == BK_IDLE))
    else $error("evaluation did not end after last beat");

endmodule

`default_nettype wire

// ===== src/softmax_probabilities_with_jacobian_top.sv =====
// Top level of the softmax probability / Jacobian block for a pair of individuals.
// Depends on smxj_pkg, smxj_front, smxj_fifo, smxj_back.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------
//   input   | in        | push / full           | beta_first, beta_second, random_effect
//   result  | out       | empty / pop           | individual .. last_result
//   config  | in        | cfg_valid / cfg_ready | cause_count (3 bits)
//
// Each input beat runs two exponentials in the front on one iterative unit,
// each of 14 Taylor steps plus 4 squarings.
// The beat that completes an evaluation of n causes then has the back run, per
// individual, n divisions and then n rows of n result beats each.
// A two-entry queue lets the front load the next beat while the back evaluates.
// Reset clears control, the cause count (to 4) and both denominators (to one);
// the exponential store has no reset. Results wait in a two-entry output queue.
`timescale 1ns / 1ps
`default_nettype none

module softmax_probabilities_with_jacobian_top #(
  parameter int unsigned MAX_CAUSES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input beats
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] beta_first_i,
  input  logic signed [15:0] beta_second_i,
  input  logic signed [15:0] random_effect_i,
  // result beats
  output logic               empty,
  input  logic               pop,
  output logic               individual_o,
  output logic [2:0]         cause_index_o,
  output logic [2:0]         wrt_cause_o,
  output logic [15:0]        probability_o,
  output logic signed [14:0] prob_slope_o,
  output logic signed [16:0] log_prob_slope_o,
  output logic               last_result_o,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_data_i
);
  import smxj_pkg::*;

  logic [CAUSE_W-1:0] cause_count_q;

  mid_t mid_wr, mid_rd;
  logic mid_push, mid_pop, mid_full, mid_empty;
  logic [$bits(mid_t)-1:0] mid_rdata;

  res_t res_wr, res_rd;
  logic res_push, res_full;
  logic [$bits(res_t)-1:0] res_rdata;

  // config is taken whenever offered
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cause_count_q <= CAUSE_W'(4);
    end else if (cfg_valid_i) begin
      cause_count_q <= cfg_data_i;
    end
  end

  smxj_front #(.MAX_CAUSES(MAX_CAUSES)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .full_o          (full),
    .beta_first_i    (beta_first_i),
    .beta_second_i   (beta_second_i),
    .random_effect_i (random_effect_i),
    .cause_count_i   (cause_count_q),
    .mid_push_o      (mid_push),
    .mid_o           (mid_wr),
    .mid_full_i      (mid_full)
  );

  // front-to-back queue
  smxj_fifo #(.WIDTH($bits(mid_t)), .DEPTH(2)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wr),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .full_o  (mid_full)
  );

  assign mid_rd = mid_t'(mid_rdata);

  smxj_back #(.MAX_CAUSES(MAX_CAUSES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_i       (mid_rd),
    .mid_empty_i (mid_empty),
    .mid_pop_o   (mid_pop),
    .res_push_o  (res_push),
    .res_o       (res_wr),
    .res_full_i  (res_full)
  );

  // result queue; its head drives the result ports
  smxj_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wr),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty),
    .full_o  (res_full)
  );

  assign res_rd           = res_t'(res_rdata);
  assign individual_o     = res_rd.individual;
  assign cause_index_o    = res_rd.cause_index;
  assign wrt_cause_o      = res_rd.wrt_cause;
  assign probability_o    = res_rd.probability;
  assign prob_slope_o     = $signed(res_rd.prob_slope);
  assign log_prob_slope_o = $signed(res_rd.log_prob_slope);
  assign last_result_o    = res_rd.last_result;

endmodule

`default_nettype wire

// ===== bench/softmax_probabilities_with_jacobian_top_test.sv =====
// Self-checking bench for softmax_probabilities_with_jacobian_top: directed and random
// cause loads, a bit-exact predictor, result checker, stall patterns. Needs smxj_pkg and the RTL.
`timescale 1ns / 1ps

module softmax_probabilities_with_jacobian_top_test;
  import smxj_pkg::*;

  localparam int MAXC = 4;
  localparam int STALL_LIMIT = 20000;  // cycles with no beat moving at all

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic signed [15:0] beta_first_i, beta_second_i, random_effect_i;
  logic               empty;
  logic               pop;
  logic               individual_o;
  logic [2:0]         cause_index_o, wrt_cause_o;
  logic [15:0]        probability_o;
  logic signed [14:0] prob_slope_o;
  logic signed [16:0] log_prob_slope_o;
  logic               last_result_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_data_i;

  softmax_probabilities_with_jacobian_top #(.MAX_CAUSES(MAXC)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full),
    .beta_first_i(beta_first_i), .beta_second_i(beta_second_i),
    .random_effect_i(random_effect_i),
    .empty(empty), .pop(pop),
    .individual_o(individual_o), .cause_index_o(cause_index_o),
    .wrt_cause_o(wrt_cause_o), .probability_o(probability_o),
    .prob_slope_o(prob_slope_o), .log_prob_slope_o(log_prob_slope_o),
    .last_result_o(last_result_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: mirrors the block's count register, exp store, denominators
  // ---------------------------------------------------------------------------
  logic [2:0]  pred_count;
  logic [31:0] pred_exp [2][MAXC];
  logic [63:0] pred_den [2];
  int          pred_loaded;
  res_t        pending_results[$];

  int n_errors = 0;
  int n_beats_in = 0;
  int n_results = 0;
  int n_evals = 0;
  int n_full_seen = 0;
  bit long_hold = 1'b0;    // receiver holds off while set
  bit pop_pattern = 1'b1;  // random receiver stalls enabled
  bit send_gaps = 1'b1;    // random sender gaps enabled

  // e^x, x in Q4.12, result Q12.20; signed 64-bit Taylor then four squarings
  function automatic logic [31:0] exp_q20(input logic signed [15:0] x);
    longint t, term, sum;
    longint unsigned r;
    t = longint'(x) * 16384;
    term = 64'sd1 << 30;
    sum = term;
    for (int k = 1; k <= 14; k++) begin
      term = (term * t) / (longint'(k) * (64'sd1 << 30));
      sum += term;
    end
    r = (unsigned'(sum) + 8) >> 4;
    for (int k = 0; k < 4; k++) r = (r * r + (64'd1 << 25)) >> 26;
    return 32'((r + 32) >> 6);
  endfunction

  function automatic logic signed [15:0] clamp_sum(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
    int s;
    s = int'(a) + int'(b);
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return 16'(s);
  endfunction

  // Load one cause; on the closing cause queue the full set of 2*n*n results.
  task automatic predict_load(input logic signed [15:0] bf, input logic signed [15:0] bs,
                              input logic signed [15:0] re);
    int n, slot;
    logic [31:0] e;
    longint unsigned q[MAXC];
    longint unsigned den, p, pd, rest;
    longint slope, lslope;
    res_t r;
    n = pred_count;
    if (n < 1) n = 1;
    if (n > MAXC) n = MAXC;
    if (pred_loaded >= n) pred_loaded = 0;
    slot = pred_loaded;
    for (int j = 0; j < 2; j++) begin
      e = exp_q20(clamp_sum(j == 0 ? bf : bs, re));
      pred_exp[j][slot] = e;
      pred_den[j] = (slot == 0) ? (64'd1 << 20) + e : pred_den[j] + e;
    end
    pred_loaded = slot + 1;
    if (pred_loaded < n) return;
    pred_loaded = 0;
    n_evals++;
    for (int j = 0; j < 2; j++) begin
      den = pred_den[j];
      for (int k = 0; k < n; k++)
        q[k] = ((64'(pred_exp[j][k]) << 30) + (den >> 1)) / den;
      for (int k = 0; k < n; k++) begin
        p = (q[k] + (64'd1 << 14)) >> 15;
        for (int d = 0; d < n; d++) begin
          if (d == k) begin
            rest = (q[k] <= (64'd1 << 30)) ? (64'd1 << 30) - q[k] : 0;
            slope = longint'((q[k] * rest + (64'd1 << 44)) >> 45);
            lslope = 32768 - longint'(p);
          end else begin
            pd = (q[d] + (64'd1 << 14)) >> 15;
            slope = -longint'((q[k] * q[d] + (64'd1 << 44)) >> 45);
            lslope = -longint'(pd);
          end
          r.individual = 1'(j);
          r.cause_index = 3'(k);
          r.wrt_cause = 3'(d);
          r.probability = 16'(p);
          r.prob_slope = 15'(slope);
          r.log_prob_slope = 17'(lslope);
          r.last_result = (j == 1 && k == n - 1 && d == n - 1);
          pending_results.push_back(r);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: one beat, bursts with random gaps between them
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_beat(input logic signed [15:0] bf, input logic signed [15:0] bs,
                           input logic signed [15:0] re);
    if (send_gaps && burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      if (push) push <= 1'b0;
      repeat ($urandom_range(0, 30)) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    push <= 1'b1;
    beta_first_i <= bf;
    beta_second_i <= bs;
    random_effect_i <= re;
    do begin
      @(posedge clk_i);
      if (full) n_full_seen++;
    end while (full);
    predict_load(bf, bs, re);
    n_beats_in++;
  endtask

  task automatic stop_push();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every predicted result is out, then let a trailing partial load settle.
  task automatic drain();
    stop_push();
    wait (pending_results.size() == 0);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [2:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    pred_count = v;
  endtask

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // Mostly moderate sums so probabilities are nontrivial, sometimes anything.
  function automatic logic signed [15:0] rnd_q412();
    if ($urandom_range(0, 3) == 0) return rnd16();
    return 16'($signed($urandom_range(0, 24576)) - 12288);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= !long_hold && (!pop_pattern || ($urandom_range(0, 3) != 0));
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && pop && !empty) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (individual_o !== want.individual) begin
          $error("individual exp %0d got %0d", want.individual, individual_o); n_errors++;
        end
        if (cause_index_o !== want.cause_index) begin
          $error("cause_index exp %0d got %0d", want.cause_index, cause_index_o); n_errors++;
        end
        if (wrt_cause_o !== want.wrt_cause) begin
          $error("wrt_cause exp %0d got %0d", want.wrt_cause, wrt_cause_o); n_errors++;
        end
        if (probability_o !== want.probability) begin
          $error("probability exp %0d got %0d", want.probability, probability_o);
          n_errors++;
        end
        if (prob_slope_o !== want.prob_slope) begin
          $error("prob_slope exp %0d got %0d", $signed(want.prob_slope), prob_slope_o);
          n_errors++;
        end
        if (log_prob_slope_o !== want.log_prob_slope) begin
          $error("log_prob_slope exp %0d got %0d", $signed(want.log_prob_slope),
                 log_prob_slope_o);
          n_errors++;
        end
        if (last_result_o !== want.last_result) begin
          $error("last_result exp %0d got %0d", want.last_result, last_result_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on any channel.
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Field extremes, saturation both ways, all bits toggled, default count of 4.
  task automatic test_extremes();
    send_beat(16'sh7FFF, 16'sh8000, 16'sh7FFF);  // sums saturate high and land at -1
    send_beat(16'sh8000, 16'sh7FFF, 16'sh8000);  // saturates low
    send_beat(16'sh0000, 16'sh0000, 16'sh0000);
    send_beat(16'sh5555, 16'shAAAA, 16'sh0000);
    drain();
  endtask

  // Counts 0, 1, 2, 3, 5 and 7, including 0 (acts as 1) and above max (acts as max).
  task automatic test_counts();
    logic [2:0] plan[6] = '{3'd1, 3'd0, 3'd2, 3'd3, 3'd7, 3'd5};
    foreach (plan[i]) begin
      write_count(plan[i]);
      for (int c = 0; c < 4; c++) send_beat(rnd_q412(), rnd_q412(), rnd_q412());
      drain();
    end
  endtask

  // Count lowered while a partial load sits in the block: it restarts.
  task automatic test_count_lowered();
    write_count(3'd4);
    repeat (3) send_beat(rnd_q412(), rnd_q412(), rnd_q412());
    drain();
    write_count(3'd2);
    repeat (2) send_beat(rnd_q412(), rnd_q412(), rnd_q412());
    drain();
  endtask

  // Receiver held off for a long stretch while the sender keeps pushing.
  task automatic test_backpressure();
    write_count(3'd1);
    long_hold = 1'b1;
    send_gaps = 1'b0;
    fork
      repeat (12) send_beat(rnd16(), rnd16(), rnd16());
      begin
        repeat (3000) @(posedge clk_i);
        long_hold = 1'b0;
      end
    join
    send_gaps = 1'b1;
    drain();
  endtask

  // Random phases across counts; one phase with no stalls on either side.
  task automatic test_random();
    for (int ph = 0; ph < 8; ph++) begin
      write_count(ph == 0 ? 3'd4 : 3'($urandom_range(0, 7)));
      pop_pattern = (ph != 3);
      send_gaps = (ph != 3);
      repeat (11) send_beat(rnd_q412(), rnd_q412(), rnd_q412());
      drain();
    end
    pop_pattern = 1'b1;
    send_gaps = 1'b1;
  endtask

  initial begin
    push = 1'b0;
    beta_first_i = '0;
    beta_second_i = '0;
    random_effect_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    pred_count = 3'd4;
    pred_loaded = 0;
    pred_den[0] = 64'd1 << 20;
    pred_den[1] = 64'd1 << 20;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_counts();
    test_count_lowered();
    test_backpressure();
    test_random();

    $display("Covered %0d input beats, %0d evaluations, %0d result beats checked;",
             n_beats_in, n_evals, n_results);
    $display("counts 0..7, saturation, restart on lowered count, %0d full stalls seen.",
             n_full_seen);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/smxj_pkg.sv
src/smxj_fifo.sv
src/smxj_exp.sv
src/smxj_front.sv
src/smxj_back.sv
src/softmax_probabilities_with_jacobian_top.sv
bench/softmax_probabilities_with_jacobian_top_test.sv
